### hw/rtl/pkunpad_pkg.sv
`default_nettype none

package pkunpad_pkg;

   localparam int BLOCK_DEFAULT = 16;
   localparam int BYTE_W        = 8;
   localparam int STATUS_W      = 2;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_LENGTH = 2'd1,
      STATUS_BAD_PAD    = 2'd2,
      STATUS_MISMATCH   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_FLUSH,
      ST_VERDICT
   } state_type;

   // Shared controls broadcast to every cell of the chain
   typedef struct packed {
      logic              shift;
      logic [BYTE_W-1:0] new_byte;
      logic [BYTE_W-1:0] pad;
   } cell_ctrl_type;

endpackage

`default_nettype wire

### hw/rtl/pkunpad_req_if.sv
`default_nettype none

interface pkunpad_req_if;
   logic                             valid;
   logic                             ready;
   logic [pkunpad_pkg::BYTE_W-1:0]   data_byte;
   logic                             final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink (input valid, input data_byte, input final_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/pkunpad_rsp_if.sv
`default_nettype none

interface pkunpad_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [pkunpad_pkg::BYTE_W-1:0]     out_byte;
   logic                               is_verdict;
   logic [pkunpad_pkg::STATUS_W-1:0]   status;

   modport source (output valid, output out_byte, output is_verdict, output status,
                   input ready);
   modport sink (input valid, input out_byte, input is_verdict, input status,
                 output ready);
endinterface

`default_nettype wire

### hw/rtl/pkunpad_cell.sv
`default_nettype none

// One byte of the holding chain. Loads the incoming byte when addressed,
// otherwise takes its upper neighbor on a shift. Flags a pad mismatch when
// it sits inside the pad region of the final block.
module pkunpad_cell #(
   parameter int BLOCK = pkunpad_pkg::BLOCK_DEFAULT,
   parameter int INDEX = 0
) (
   input  wire                                clock,
   input  pkunpad_pkg::cell_ctrl_type         ctrl,
   input  wire                                load,
   input  wire  [pkunpad_pkg::BYTE_W-1:0]     neighbor_byte,
   output logic [pkunpad_pkg::BYTE_W-1:0]     data_byte,
   output logic                               miss
);

   localparam logic REAL_CELL = (INDEX < BLOCK - 1);

   logic [pkunpad_pkg::BYTE_W-1:0] data_ff;
   logic [pkunpad_pkg::BYTE_W-1:0] data_in;
   logic [pkunpad_pkg::BYTE_W:0]   reach;
   logic                           in_pad;

   always_comb begin
      data_in = data_ff;
      if (load) begin
         data_in = ctrl.new_byte;
      end else if (ctrl.shift) begin
         data_in = neighbor_byte;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   // cell is covered by padding when INDEX >= BLOCK - pad
   assign reach  = {1'b0, ctrl.pad} + (pkunpad_pkg::BYTE_W+1)'(INDEX);
   assign in_pad = REAL_CELL && (reach >= (pkunpad_pkg::BYTE_W+1)'(BLOCK));

   assign data_byte = data_ff;
   assign miss      = in_pad && (data_ff != ctrl.pad);

endmodule

`default_nettype wire

### hw/rtl/pkcs7_unpad_stream_top.sv
`default_nettype none

// Streaming PKCS#7 unpadder. Message bytes enter one per cycle on req_chan
// while the output register is free, the last one flagged by final_byte;
// the newest BLOCK-1 bytes sit in a chain of byte cells, and each byte
// pushed off the bottom of the chain goes out on rsp_chan. Once the final
// byte is taken, a check state tests length, pad value and pad bytes
// against the chain; when the checks pass, the unpadded bytes are shifted
// out of the chain one per cycle while the output register is free, and
// then the closing status item follows. No new request is taken until
// the status item has been loaded into the output register. Bytes
// emitted before the status item belong to the message already; a consumer
// drops the message when the status is not ok (1 bad length, 2 bad pad value,
// 3 pad bytes mismatch).
module pkcs7_unpad_stream_top #(
   parameter int BLOCK = pkunpad_pkg::BLOCK_DEFAULT
) (
   input  wire                   clock,
   input  wire                   reset,
   pkunpad_req_if.sink           req_chan,
   pkunpad_rsp_if.source         rsp_chan
);

   localparam int NCELL = (BLOCK > 1) ? BLOCK - 1 : 1;
   localparam int PosW  = (BLOCK > 1) ? $clog2(BLOCK) : 1;
   localparam int BW    = pkunpad_pkg::BYTE_W;
   localparam logic [PosW-1:0] LastPos = PosW'(BLOCK - 1);

   pkunpad_pkg::state_type  state_ff, state_in;
   logic [PosW-1:0]         pos_ff, pos_in;
   logic                    full_ff, full_in;
   logic [BW-1:0]           pad_ff, pad_in;
   logic                    len_ok_ff, len_ok_in;
   logic [PosW-1:0]         cnt_ff, cnt_in;
   pkunpad_pkg::status_type st_ff, st_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]           rsp_byte_ff, rsp_byte_in;
   logic                    rsp_verdict_ff, rsp_verdict_in;
   logic [pkunpad_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                    slot_free;
   logic                    req_ready;
   logic                    req_fire;
   logic                    fire_body;
   logic [PosW-1:0]         held;
   logic                    emit;
   logic                    pad_ok;
   logic                    mismatch;
   pkunpad_pkg::status_type check_st;
   logic [BW:0]             keep_wide;
   logic [PosW-1:0]         keep_cnt;
   logic [BW-1:0]           head_byte;

   logic                    shift;
   logic                    load_byte;
   logic                    load_verdict;

   pkunpad_pkg::cell_ctrl_type ctrl;
   logic [BW-1:0]           cell_data [NCELL];
   logic [BW-1:0]           cell_next [NCELL];
   logic [NCELL-1:0]        cell_load;
   logic [NCELL-1:0]        cell_miss;

   // ---------------------------------------------------------------- datapath
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire  = req_chan.valid && req_ready;
   assign fire_body = req_fire && !req_chan.final_byte;
   assign held      = full_ff ? LastPos : pos_ff;
   assign emit      = (held == LastPos);

   assign pad_ok    = (pad_ff != '0) && (pad_ff <= BW'(BLOCK));
   assign mismatch  = |cell_miss;
   assign keep_wide = (BW+1)'(BLOCK) - {1'b0, pad_ff};
   assign keep_cnt  = keep_wide[PosW-1:0];

   always_comb begin
      if (!len_ok_ff) begin
         check_st = pkunpad_pkg::STATUS_BAD_LENGTH;
      end else if (!pad_ok) begin
         check_st = pkunpad_pkg::STATUS_BAD_PAD;
      end else if (mismatch) begin
         check_st = pkunpad_pkg::STATUS_MISMATCH;
      end else begin
         check_st = pkunpad_pkg::STATUS_OK;
      end
   end

   // with a one-byte block the chain is bypassed and bytes pass straight on
   assign head_byte = (BLOCK > 1) ? cell_data[0] : req_chan.data_byte;

   // ---------------------------------------------------------------- cells
   assign ctrl.shift    = shift;
   assign ctrl.new_byte = req_chan.data_byte;
   assign ctrl.pad      = pad_ff;

   genvar g;
   generate
      for (g = 0; g < NCELL; g++) begin : g_cell
         if (g == NCELL - 1) begin : g_top
            assign cell_next[g] = req_chan.data_byte;
         end else begin : g_mid
            assign cell_next[g] = cell_data[g+1];
         end

         assign cell_load[g] = fire_body && !emit && (held == PosW'(g));

         pkunpad_cell #(
            .BLOCK (BLOCK),
            .INDEX (g)
         ) u_cell (
            .clock         (clock),
            .ctrl          (ctrl),
            .load          (cell_load[g]),
            .neighbor_byte (cell_next[g]),
            .data_byte     (cell_data[g]),
            .miss          (cell_miss[g])
         );
      end
   endgenerate

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pkunpad_pkg::ST_IDLE: begin
            if (req_fire && req_chan.final_byte) begin
               state_in = pkunpad_pkg::ST_CHECK;
            end
         end
         pkunpad_pkg::ST_CHECK: begin
            if (check_st == pkunpad_pkg::STATUS_OK && keep_cnt != '0) begin
               state_in = pkunpad_pkg::ST_FLUSH;
            end else begin
               state_in = pkunpad_pkg::ST_VERDICT;
            end
         end
         pkunpad_pkg::ST_FLUSH: begin
            if (slot_free && cnt_ff == PosW'(1)) begin
               state_in = pkunpad_pkg::ST_VERDICT;
            end
         end
         pkunpad_pkg::ST_VERDICT: begin
            if (slot_free) begin
               state_in = pkunpad_pkg::ST_IDLE;
            end
         end
         default: state_in = pkunpad_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_ready    = 1'b0;
      shift        = 1'b0;
      load_byte    = 1'b0;
      load_verdict = 1'b0;
      case (state_ff)
         pkunpad_pkg::ST_IDLE: begin
            req_ready = slot_free;
            shift     = fire_body && emit;
            load_byte = fire_body && emit;
         end
         pkunpad_pkg::ST_CHECK: begin
         end
         pkunpad_pkg::ST_FLUSH: begin
            shift     = slot_free;
            load_byte = slot_free;
         end
         pkunpad_pkg::ST_VERDICT: begin
            load_verdict = slot_free;
         end
         default: begin
         end
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_comb begin
      pos_in    = pos_ff;
      full_in   = full_ff;
      pad_in    = pad_ff;
      len_ok_in = len_ok_ff;
      cnt_in    = cnt_ff;
      st_in     = st_ff;

      if (fire_body) begin
         if (pos_ff == LastPos) begin
            pos_in  = '0;
            full_in = 1'b1;
         end else begin
            pos_in = pos_ff + PosW'(1);
         end
      end else if (req_fire) begin
         // final byte closes the run
         pos_in    = '0;
         full_in   = 1'b0;
         pad_in    = req_chan.data_byte;
         len_ok_in = (pos_ff == LastPos);
      end

      if (state_ff == pkunpad_pkg::ST_CHECK) begin
         st_in  = check_st;
         cnt_in = keep_cnt;
      end else if (state_ff == pkunpad_pkg::ST_FLUSH && slot_free) begin
         cnt_in = cnt_ff - PosW'(1);
      end
   end

   always_comb begin
      rsp_byte_in    = rsp_byte_ff;
      rsp_verdict_in = rsp_verdict_ff;
      rsp_status_in  = rsp_status_ff;
      if (load_byte) begin
         rsp_byte_in    = head_byte;
         rsp_verdict_in = 1'b0;
         rsp_status_in  = pkunpad_pkg::STATUS_OK;
      end else if (load_verdict) begin
         rsp_byte_in    = '0;
         rsp_verdict_in = 1'b1;
         rsp_status_in  = st_ff;
      end

      if (load_byte || load_verdict) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pkunpad_pkg::ST_IDLE;
         pos_ff       <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pad_ff         <= pad_in;
      len_ok_ff      <= len_ok_in;
      cnt_ff         <= cnt_in;
      st_ff          <= st_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_verdict_ff <= rsp_verdict_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign req_chan.ready      = req_ready;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.out_byte   = rsp_byte_ff;
   assign rsp_chan.is_verdict = rsp_verdict_ff;
   assign rsp_chan.status     = rsp_status_ff;

endmodule

`default_nettype wire

### tb/sv/pkunpad_checker.sv
`timescale 1ns / 100ps

// Watches both channels of the unpadder, predicts the response stream from the
// accepted requests and compares every accepted response with the oldest
// prediction.
module pkunpad_checker
   import pkunpad_pkg::*;
#(
   parameter int BLOCK = BLOCK_DEFAULT
) (
   input  wire     clock,
   input  wire     reset,
   pkunpad_req_if  req_mon,
   pkunpad_rsp_if  rsp_mon,
   output int      fail_count,
   output int      pending
);

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              is_verdict;
      status_type        status;
   } unpad_item_type;

   logic [BYTE_W-1:0] chain [0:BLOCK-1];
   int unsigned       block_pos;
   bit                block_seen;
   unpad_item_type    unpad_expect_q[$];
   int                mismatch_count = 0;
   int                expect_count   = 0;

   assign fail_count = mismatch_count;
   assign pending    = expect_count;

   function automatic void push_expect(logic [BYTE_W-1:0] b, logic v, status_type s);
      unpad_item_type item;
      item.out_byte   = b;
      item.is_verdict = v;
      item.status     = s;
      unpad_expect_q.push_back(item);
   endfunction

   task automatic predict_unpad(input logic [BYTE_W-1:0] data_byte, input logic final_byte);
      int unsigned held;
      int unsigned pad;
      int unsigned i;
      status_type  st;
      held = block_seen ? BLOCK - 1 : block_pos;
      if (!final_byte) begin
         if (held == BLOCK - 1) begin
            if (BLOCK > 1) begin
               // chain full: oldest byte falls out
               push_expect(chain[0], 1'b0, STATUS_OK);
               for (i = 0; i + 2 < BLOCK; i++)
                  chain[i] = chain[i+1];
               chain[(BLOCK > 1) ? BLOCK - 2 : 0] = data_byte;
            end else begin
               // one-byte block: nothing is held
               push_expect(data_byte, 1'b0, STATUS_OK);
            end
         end else begin
            chain[held] = data_byte;
         end
         block_pos++;
         if (block_pos == BLOCK) begin
            block_pos  = 0;
            block_seen = 1'b1;
         end
      end else begin
         st  = STATUS_OK;
         pad = data_byte;
         if (block_pos != BLOCK - 1) begin
            st = STATUS_BAD_LENGTH;
         end else if (pad == 0 || pad > BLOCK) begin
            st = STATUS_BAD_PAD;
         end else begin
            chain[BLOCK-1] = data_byte;
            for (i = BLOCK - pad; i < BLOCK; i++)
               if (chain[i] != data_byte)
                  st = STATUS_MISMATCH;
            if (st == STATUS_OK)
               for (i = 0; i < BLOCK - pad; i++)
                  push_expect(chain[i], 1'b0, STATUS_OK);
         end
         push_expect('0, 1'b1, st);
         block_pos  = 0;
         block_seen = 1'b0;
      end
   endtask

   always @(posedge clock) begin : monitor
      unpad_item_type exp_item;
      if (reset) begin
         unpad_expect_q.delete();
         block_pos  = 0;
         block_seen = 1'b0;
         for (int i = 0; i < BLOCK; i++)
            chain[i] = '0;
      end else begin
         // responses first: nothing accepted at this edge can already be answered
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (unpad_expect_q.size() == 0) begin
               $error("unexpected response: out_byte %02h is_verdict %0d status %0d",
                      rsp_mon.out_byte, rsp_mon.is_verdict, rsp_mon.status);
               mismatch_count++;
            end else begin
               exp_item = unpad_expect_q.pop_front();
               if (rsp_mon.out_byte !== exp_item.out_byte) begin
                  $error("out_byte: expected %02h, got %02h",
                         exp_item.out_byte, rsp_mon.out_byte);
                  mismatch_count++;
               end
               if (rsp_mon.is_verdict !== exp_item.is_verdict) begin
                  $error("is_verdict: expected %0d, got %0d",
                         exp_item.is_verdict, rsp_mon.is_verdict);
                  mismatch_count++;
               end
               if (rsp_mon.status !== exp_item.status) begin
                  $error("status: expected %0d, got %0d", exp_item.status, rsp_mon.status);
                  mismatch_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_unpad(req_mon.data_byte, req_mon.final_byte);
      end
      expect_count = unpad_expect_q.size();
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
   import pkunpad_pkg::*;

   localparam int          BLOCK       = BLOCK_DEFAULT;
   localparam int unsigned RANDOM_MIN  = 350;
   localparam int unsigned LONG_HOLD   = 150;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef logic [BYTE_W-1:0] byte_q_type[$];

   typedef enum int {
      MSG_GOOD,
      MSG_BAD_LENGTH,
      MSG_BAD_PAD,
      MSG_MISMATCH
   } msg_kind_type;

   logic        clock;
   logic        reset;
   int          fail_count;
   int          pending;
   bit          hold_off_req = 1'b0;
   bit          no_gaps      = 1'b0;
   int unsigned bytes_sent   = 0;

   pkunpad_req_if req_chan ();
   pkunpad_rsp_if rsp_chan ();

   pkcs7_unpad_stream_top #(
      .BLOCK (BLOCK)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   pkunpad_checker #(
      .BLOCK (BLOCK)
   ) i_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned idle_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_byte(input logic [BYTE_W-1:0] data_byte, input logic final_byte);
      int unsigned gap;
      gap = no_gaps ? 0 : idle_gap();
      if (gap != 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.data_byte  <= data_byte;
      req_chan.final_byte <= final_byte;
      do @(posedge clock); while (!req_chan.ready);
      bytes_sent++;
   endtask

   task automatic send_message(input byte_q_type msg);
      for (int i = 0; i < msg.size(); i++)
         send_byte(msg[i], i == msg.size() - 1);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic send_random_message();
      byte_q_type   msg;
      msg_kind_type kind;
      int unsigned  r;
      int unsigned  len;
      int unsigned  pad;
      int unsigned  pos;
      r = $urandom_range(0, 9);
      kind = (r < 6) ? MSG_GOOD : (r == 6) ? MSG_BAD_LENGTH :
             (r == 7) ? MSG_BAD_PAD : MSG_MISMATCH;
      if (kind == MSG_BAD_LENGTH) begin
         len = $urandom_range(1, 40);
         if (len % BLOCK == 0)
            len++;
      end else begin
         len = BLOCK * (($urandom_range(0, 9) == 0) ? $urandom_range(3, 4)
                                                     : $urandom_range(1, 2));
      end
      for (int i = 0; i < len; i++)
         msg.push_back(BYTE_W'($urandom_range(0, 255)));
      case (kind)
         MSG_GOOD: begin
            pad = $urandom_range(1, BLOCK);
            for (int i = len - pad; i < len; i++)
               msg[i] = BYTE_W'(pad);
         end
         MSG_BAD_PAD: begin
            msg[len-1] = $urandom_range(0, 1) ? '0 : BYTE_W'($urandom_range(BLOCK + 1, 255));
         end
         MSG_MISMATCH: begin
            pad = $urandom_range(2, BLOCK);
            for (int i = len - pad; i < len; i++)
               msg[i] = BYTE_W'(pad);
            // spoil one pad byte other than the last
            pos      = len - pad + $urandom_range(0, pad - 2);
            msg[pos] = BYTE_W'(pad) ^ BYTE_W'($urandom_range(1, 255));
         end
         default: ;
      endcase
      no_gaps = ($urandom_range(0, 3) == 0);
      send_message(msg);
   endtask

   // response side: random ready with bursts, plus long hold-offs on request
   initial begin : rsp_ready_drive
      int unsigned burst;
      int unsigned gap;
      rsp_chan.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
            rsp_chan.ready <= 1'b1;
            repeat (burst) @(posedge clock);
            gap = idle_gap();
            if (gap != 0) begin
               rsp_chan.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      byte_q_type  msg;
      int unsigned msg_count;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.data_byte  <= '0;
      req_chan.final_byte <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pad of one: most bytes out of a single final block
      msg = '{8'h00, 8'hFF, 8'h55, 8'hAA};
      repeat (BLOCK - 5) msg.push_back(BYTE_W'($urandom_range(0, 255)));
      msg.push_back(8'h01);
      send_message(msg);
      // lone final byte with a legal pad value: length check wins
      msg = '{8'h10};
      send_message(msg);
      // half block
      msg = {};
      repeat (8) msg.push_back(BYTE_W'($urandom_range(0, 255)));
      send_message(msg);
      drain();

      hold_off_req = 1'b1;
      msg_count    = 0;
      while (bytes_sent < RANDOM_MIN) begin
         send_random_message();
         msg_count++;
         if (msg_count == 8)
            hold_off_req = 1'b1;
         if (msg_count == 12)
            drain();
      end
      no_gaps = 1'b0;
      drain();
      repeat (3 * BLOCK) @(posedge clock);

      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
